FILE: hw/rtl/clh_pkg.sv
// ----------------------------------------------------------------------------
// clh_pkg: shared types and functions for the case-folded lookup2 hash
// Fold and sign-extend of one character, one line of the lookup2 mix,
// and the records that travel between pipeline sections.
// ----------------------------------------------------------------------------
`default_nettype none

package clh_pkg;

  localparam logic [31:0] GOLDEN_SEED = 32'h9e3779b9;
  localparam logic [3:0]  BLOCK_BYTES = 4'd12;
  localparam logic [31:0] EMPTY_ID    = 32'hFFFFFFFF;

  // lines in one full mix; the mix pipe registers every line but the last
  localparam int MIX_LINES   = 9;
  // cycles a finish request waits so the last block mix has landed in base
  localparam int FINAL_DELAY = 10;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } mix_state_t;

  // finish request: addends still owed to the state before the final mix
  typedef struct packed {
    logic        empty;
    logic        use_base;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic [31:0] add_c_lane;
    logic [31:0] add_len;
  } final_job_t;

  // fold a-z to upper case, then sign-extend as a signed char
  function automatic logic [31:0] fold_extend(input logic [7:0] ch);
    logic [7:0] u;
    u = ch;
    if (ch inside {[8'h61:8'h7A]}) begin
      u = ch - 8'h20;
    end
    return {{24{u[7]}}, u};
  endfunction

  // one line of the lookup2 mix; each line rewrites a single word
  function automatic mix_state_t mix_step(input mix_state_t s, input logic [3:0] line);
    mix_state_t r;
    r = s;
    case (line)
      4'd0: r.a = (s.a - s.b - s.c) ^ (s.c >> 13);
      4'd1: r.b = (s.b - s.c - s.a) ^ (s.a << 8);
      4'd2: r.c = (s.c - s.a - s.b) ^ (s.b >> 13);
      4'd3: r.a = (s.a - s.b - s.c) ^ (s.c >> 12);
      4'd4: r.b = (s.b - s.c - s.a) ^ (s.a << 16);
      4'd5: r.c = (s.c - s.a - s.b) ^ (s.b >> 5);
      4'd6: r.a = (s.a - s.b - s.c) ^ (s.c >> 3);
      4'd7: r.b = (s.b - s.c - s.a) ^ (s.a << 10);
      4'd8: r.c = (s.c - s.a - s.b) ^ (s.b >> 15);
      default: r = s;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/case_folded_lookup2_hash.sv
// ----------------------------------------------------------------------------
// case_folded_lookup2_hash: streaming case-folded lookup2 string hash
// Takes one character per request, emits one 32-bit hash per string.
// ----------------------------------------------------------------------------
//
//   channel | side   | contents
//   --------+--------+------------------------------------------------------
//   s_*     | in     | tdata: char_byte[7:0]; tlast: last; tuser: empty_req
//   m_*     | out    | tdata: hash_value[31:0]
//
// One character is accepted every cycle while the output is not stalled.
// Once its last character (or empty request) is accepted, a hash passes the
// block-mix wait, one combine stage and the 9-line mix to the output register.
// Block mixes run in their own 9-line pipeline while the next block collects.
// Reset clears all control state at once; no clearing pass.
// The pipeline holds only when a finished hash meets a full, stalled output.
//
`default_nettype none

module case_folded_lookup2_hash
  import clh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_byte[7:0]
  input  logic        s_tlast,
  input  logic        s_tuser,   // empty_req
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // hash_value[31:0]
);

  localparam int M2_STAGES = MIX_LINES - 1;

  logic adv;
  logic accept;

  // collect stage
  logic [3:0]  pos;
  logic [3:0]  pos_eff;
  logic [31:0] col_a;
  logic [31:0] col_b;
  logic [31:0] col_c;
  logic [31:0] len;
  logic        have_base;
  logic [31:0] ch_lane;
  logic [31:0] col_a_sum;
  logic [31:0] col_b_sum;
  logic [31:0] col_c_sum;
  logic [31:0] len_sum;
  logic        full;
  logic        str_end;

  // block mix
  mix_state_t  base;
  mix_state_t  launch_st;
  mix_state_t  launch_sum;
  logic        l1_valid;
  logic        m1_out_valid;
  mix_state_t  m1_out;
  logic        m1_busy;

  // finish path
  final_job_t             job_in;
  final_job_t             dly [1:FINAL_DELAY];
  logic [FINAL_DELAY:1]   dly_valid;
  final_job_t             job_out;
  mix_state_t             fin_st;
  mix_state_t             fin_st_next;
  logic                   fin_valid;
  logic                   fin_empty;
  logic [M2_STAGES:1]     empty_line;
  logic                   m2_out_valid;
  mix_state_t             m2_out;
  logic                   m2_busy;

  assign adv      = !(m2_out_valid && m_tvalid && !m_tready);
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;
  assign str_end  = s_tlast || s_tuser;

  always_comb begin
    pos_eff   = (pos >= BLOCK_BYTES) ? 4'd0 : pos;
    ch_lane   = fold_extend(s_tdata) << {pos_eff[1:0], 3'b000};
    col_a_sum = col_a;
    col_b_sum = col_b;
    col_c_sum = col_c;
    case (pos_eff[3:2])
      2'd0:    col_a_sum = col_a + ch_lane;
      2'd1:    col_b_sum = col_b + ch_lane;
      default: col_c_sum = col_c + ch_lane;
    endcase
    len_sum = len + 32'd1;
    full    = (pos_eff == BLOCK_BYTES - 4'd1);

    launch_sum.a = (have_base ? base.a : GOLDEN_SEED) + col_a_sum;
    launch_sum.b = (have_base ? base.b : GOLDEN_SEED) + col_b_sum;
    launch_sum.c = (have_base ? base.c : 32'd0) + col_c_sum;

    // a block that closes on the last byte leaves only the length owed
    job_in.empty      = s_tuser;
    job_in.use_base   = have_base || full;
    job_in.add_a      = full ? 32'd0 : col_a_sum;
    job_in.add_b      = full ? 32'd0 : col_b_sum;
    job_in.add_c_lane = full ? 32'd0 : col_c_sum;
    job_in.add_len    = len_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      col_a     <= '0;
      col_b     <= '0;
      col_c     <= '0;
      len       <= '0;
      have_base <= 1'b0;
    end else if (accept) begin
      if (str_end) begin
        pos       <= '0;
        col_a     <= '0;
        col_b     <= '0;
        col_c     <= '0;
        len       <= '0;
        have_base <= 1'b0;
      end else begin
        pos       <= full ? 4'd0 : pos_eff + 4'd1;
        col_a     <= full ? 32'd0 : col_a_sum;
        col_b     <= full ? 32'd0 : col_b_sum;
        col_c     <= full ? 32'd0 : col_c_sum;
        len       <= len_sum;
        have_base <= have_base || full;
      end
    end
  end

  // block mix launch
  always_ff @(posedge clk) begin
    if (rst) begin
      l1_valid <= 1'b0;
    end else if (adv) begin
      l1_valid <= accept && !s_tuser && full;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      launch_st <= launch_sum;
    end
  end

  clh_mix_pipe u_block_mix (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (l1_valid),
    .in_st     (launch_st),
    .out_valid (m1_out_valid),
    .out_st    (m1_out),
    .busy      (m1_busy)
  );

  always_ff @(posedge clk) begin
    if (adv && m1_out_valid) begin
      base <= m1_out;
    end
  end

  // hold finish requests until the block mix of their string has landed
  always_ff @(posedge clk) begin
    if (rst) begin
      dly_valid <= '0;
    end else if (adv) begin
      dly_valid <= {dly_valid[FINAL_DELAY-1:1], accept && str_end};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dly[1] <= job_in;
      for (int i = 2; i <= FINAL_DELAY; i++) begin
        dly[i] <= dly[i-1];
      end
    end
  end

  assign job_out = dly[FINAL_DELAY];

  always_comb begin
    fin_st_next.a = (job_out.use_base ? base.a : GOLDEN_SEED) + job_out.add_a;
    fin_st_next.b = (job_out.use_base ? base.b : GOLDEN_SEED) + job_out.add_b;
    fin_st_next.c = (job_out.use_base ? base.c : 32'd0)
                  + {job_out.add_c_lane[23:0], 8'h00} + job_out.add_len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (adv) begin
      fin_valid <= dly_valid[FINAL_DELAY];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_st     <= fin_st_next;
      fin_empty  <= job_out.empty;
      empty_line <= {empty_line[M2_STAGES-1:1], fin_empty};
    end
  end

  clh_mix_pipe u_final_mix (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (fin_valid),
    .in_st     (fin_st),
    .out_valid (m2_out_valid),
    .out_st    (m2_out),
    .busy      (m2_busy)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && m2_out_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && m2_out_valid) begin
      m_tdata <= empty_line[M2_STAGES] ? EMPTY_ID : m2_out.c;
    end
  end

  // a new block mix must find the previous one finished and written to base
  a_launch_idle: assert property (@(posedge clk) disable iff (rst)
    accept && !s_tuser && full |-> !l1_valid && !m1_busy)
    else $error("block mix launched while an earlier one is in flight");

  // a finish that reads base must not race a block mix still in flight
  a_final_base_ready: assert property (@(posedge clk) disable iff (rst)
    dly_valid[FINAL_DELAY] && !job_out.empty && job_out.use_base
      |-> !l1_valid && !m1_busy)
    else $error("finish read base before the block mix landed");

  // string end returns the collect stage to its start state
  a_string_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && str_end |=> pos == '0 && len == '0 && !have_base)
    else $error("collect state not cleared after string end");

  // input stalls only while the finish pipeline holds a hash
  a_stall_needs_work: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m2_busy)
    else $error("input stalled with an idle finish pipeline");

endmodule

`default_nettype wire

FILE: hw/rtl/clh_mix_pipe.sv
// ----------------------------------------------------------------------------
// clh_mix_pipe: pipelined lookup2 mix
// One mix line per stage; the last line is left combinational so the
// caller can register the result where it needs it.
// ----------------------------------------------------------------------------
`default_nettype none

module clh_mix_pipe
  import clh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  mix_state_t in_st,
  output logic       out_valid,
  output mix_state_t out_st,
  output logic       busy
);

  localparam int STAGES = MIX_LINES - 1;

  logic [STAGES:1] vld;
  mix_state_t      st      [1:STAGES];
  mix_state_t      st_next [1:STAGES];

  always_comb begin
    st_next[1] = mix_step(in_st, 4'd0);
    for (int i = 2; i <= STAGES; i++) begin
      st_next[i] = mix_step(st[i-1], 4'(i - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 1; i <= STAGES; i++) begin
        st[i] <= st_next[i];
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign out_st    = mix_step(st[STAGES], 4'(STAGES));
  assign busy      = |vld;

endmodule

`default_nettype wire
